### design/iira_pkg.sv
// Package for the indexed insert/remove array: sizes, operation and status codes,
// and the control bundle that the top level hands to the cell chain.
// No dependencies.
`default_nettype none
package iira_pkg;

   localparam int CAPACITY = 64;
   localparam int POS_W    = 7;
   localparam int CNT_OUT_W = 7;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [3:0] {
      OP_INSERT_AT    = 4'd0,
      OP_INSERT_FRONT = 4'd1,
      OP_INSERT_BACK  = 4'd2,
      OP_REMOVE_AT    = 4'd3,
      OP_REMOVE_FRONT = 4'd4,
      OP_REMOVE_BACK  = 4'd5,
      OP_READ         = 4'd6,
      OP_SEARCH       = 4'd7,
      OP_CLEAR        = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              insert_en;
      logic              remove_en;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
      logic [CMP_W-1:0]  count;
   } chain_ctl_type;

endpackage
`default_nettype wire

### design/iira_cell.sv
// One storage cell of the array: holds one entry, shifts toward or away from
// its neighbors, and reports its compare match and read tap. Uses iira_pkg.
`default_nettype none
module iira_cell
   import iira_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [CMP_W-1:0]  cell_index,
   input  wire chain_ctl_type     ctl,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [DATA_W-1:0] right_data,
   output logic      [DATA_W-1:0] data_out,
   output logic                   match,
   output logic      [DATA_W-1:0] tap
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.insert_en && (cell_index > ctl.pos)) begin
         data_in = left_data;
      end else if (ctl.insert_en && (cell_index == ctl.pos)) begin
         data_in = ctl.value;
      end else if (ctl.remove_en && (cell_index >= ctl.pos)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // only stored entries take part in a search
   assign match    = (cell_index < ctl.count) && (data_ff == ctl.value);
   assign tap      = (cell_index == ctl.pos) ? data_ff : '0;

endmodule
`default_nettype wire

### design/iira_chain.sv
// Row of CAPACITY cells linked to their neighbors, with the OR of the match
// flags and of the read taps. Uses iira_pkg and iira_cell.
`default_nettype none
module iira_chain
   import iira_pkg::*;
(
   input  wire logic              clock,
   input  wire chain_ctl_type     ctl,
   output logic                   any_match,
   output logic      [DATA_W-1:0] read_data
);

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_tap  [CAPACITY];
   logic [CAPACITY-1:0] match_vec;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end
      iira_cell u_cell (
         .clock      (clock),
         .cell_index (CMP_W'(i)),
         .ctl        (ctl),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i]),
         .match      (match_vec[i]),
         .tap        (cell_tap[i])
      );
   end

   assign any_match = |match_vec;

   // at most one tap is nonzero
   always_comb begin
      read_data = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_data = read_data | cell_tap[k];
      end
   end

endmodule
`default_nettype wire

### design/indexed_insert_remove_array_top.sv
// Indexed insert/remove array: decode, entry count and result register around
// the cell chain. Uses iira_pkg and iira_chain.
// The result beat is valid in the cycle after its request beat is taken.
// Throughput: one request per cycle unless a held result beat is stalled; the
// result register frees on the same edge as its beat is taken.
// Reset clears the entry count and the result valid; stored entries are kept.
`default_nettype none
module indexed_insert_remove_array_top
   import iira_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [3:0] op, [10:4] position, [42:11] value, [47:43] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] read_value, [32] found, [39:33] count, [41:40] status, [47:42] zero
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   op_type             op;
   logic [POS_W-1:0]   position;
   logic [DATA_W-1:0]  value;
   logic               accept;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  read_value_ff, read_value_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   rsp_count_ff;
   status_type         status_ff, status_in;
   chain_ctl_type      ctl;
   logic               any_match;
   logic [DATA_W-1:0]  read_data;
   logic [CMP_W-1:0]   count_ext, pos_ext, ins_pos;
   logic               is_full;

   assign op       = op_type'(req_tdata[3:0]);
   assign position = req_tdata[10:4];
   assign value    = req_tdata[42:11];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(position);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      ctl.insert_en = 1'b0;
      ctl.remove_en = 1'b0;
      ctl.pos       = pos_ext;
      ctl.value     = value;
      ctl.count     = count_ext;
      count_in      = count_ff;
      read_value_in = '0;
      found_in      = 1'b0;
      status_in     = ST_OK;
      ins_pos       = pos_ext;
      case (op)
         OP_INSERT_AT:    ins_pos = pos_ext;
         OP_INSERT_FRONT: ins_pos = '0;
         OP_INSERT_BACK:  ins_pos = count_ext;
         default:         ins_pos = pos_ext;
      endcase
      case (op)
         OP_INSERT_AT, OP_INSERT_FRONT, OP_INSERT_BACK: begin
            ctl.pos = ins_pos;
            if (ins_pos > count_ext) begin
               status_in = ST_RANGE;
            end else if (is_full) begin
               status_in = ST_FULL;
            end else begin
               ctl.insert_en = accept;
               count_in      = count_ff + 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            if (pos_ext >= count_ext) begin
               status_in = ST_RANGE;
            end else begin
               ctl.remove_en = accept;
               count_in      = count_ff - 1'b1;
            end
         end
         OP_REMOVE_FRONT: begin
            ctl.pos = '0;
            if (count_ff != '0) begin
               ctl.remove_en = accept;
               count_in      = count_ff - 1'b1;
            end
         end
         OP_REMOVE_BACK: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext < count_ext) begin
               read_value_in = read_data;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_SEARCH: found_in = any_match;
         OP_CLEAR:  count_in = '0;
         default: ;
      endcase
   end

   iira_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .any_match (any_match),
      .read_data (read_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         found_ff      <= found_in;
         rsp_count_ff  <= count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff, CNT_OUT_W'(rsp_count_ff), found_ff, read_value_ff};

endmodule
`default_nettype wire

### design/iira_checker.sv
// Port-level checks for the indexed insert/remove array, bound to the top level.
// Uses iira_pkg.
`default_nettype none
module iira_checker
   import iira_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result beat one cycle after request");

   a_found_search: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[3:0] != OP_SEARCH) |=> !rsp_tdata[32])
      else $error("found set for a non-search request");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[41:40] == ST_FULL) |->
      rsp_tdata[39:33] == CNT_OUT_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:40] != 2'd3)
      else $error("undefined status code");

endmodule

bind indexed_insert_remove_array_top iira_checker u_iira_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### test/indexed_insert_remove_array_checker.sv
// Checker for the indexed insert/remove array: watches both stream channels,
// predicts every result beat from a shadow copy of the array and compares.
// Depends on iira_pkg for sizes and operation and status codes.
`timescale 1ns / 100ps
module indexed_insert_remove_array_checker
   import iira_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // [3:0] op, [10:4] position, [42:11] value, [47:43] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [31:0] read_value, [32] found, [39:33] count, [41:40] status, [47:42] zero
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          error_count,
   output int                          pending,
   output int                          checked_count,
   output logic [CNT_OUT_W-1:0]        stored_count
);

   typedef struct packed {
      logic [DATA_W-1:0]    read_value;
      logic                 found;
      logic [CNT_OUT_W-1:0] count;
      logic [1:0]           status;
   } rsp_fields_t;

   logic [DATA_W-1:0] shadow_entries [CAPACITY];
   int                shadow_count = 0;
   rsp_fields_t       expected_rsp_q [$];
   int                mismatches = 0;
   int                checked = 0;

   // Apply one operation to the shadow array and return the result it gives.
   function automatic rsp_fields_t apply_array_op(input logic [3:0] op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] val);
      rsp_fields_t r;
      int          ins_at;
      int          del_at;
      r = '0;
      ins_at = -1;
      del_at = -1;
      case (op)
         OP_INSERT_AT:    ins_at = int'(pos);
         OP_INSERT_FRONT: ins_at = 0;
         OP_INSERT_BACK:  ins_at = shadow_count;
         OP_REMOVE_AT: begin
            if (int'(pos) >= shadow_count) r.status = ST_RANGE;
            else del_at = int'(pos);
         end
         OP_REMOVE_FRONT: if (shadow_count > 0) del_at = 0;
         OP_REMOVE_BACK:  if (shadow_count > 0) shadow_count--;
         OP_READ: begin
            if (int'(pos) < shadow_count) r.read_value = shadow_entries[pos];
            else r.status = ST_RANGE;
         end
         OP_SEARCH: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_entries[i] == val) r.found = 1'b1;
         end
         OP_CLEAR: shadow_count = 0;
         default: ;
      endcase
      // range check on the index wins over the full check
      if (ins_at >= 0) begin
         if (ins_at > shadow_count) begin
            r.status = ST_RANGE;
         end else if (shadow_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (int i = shadow_count; i > ins_at; i--)
               shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[ins_at] = val;
            shadow_count++;
         end
      end
      if (del_at >= 0) begin
         for (int i = del_at; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
         shadow_count--;
      end
      r.count = shadow_count[CNT_OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_fields_t want;
      rsp_fields_t got;
      if (reset) begin
         shadow_count = 0;
         expected_rsp_q.delete();
      end else begin
         // a result is never for the request taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.read_value = rsp_tdata[31:0];
            got.found      = rsp_tdata[32];
            got.count      = rsp_tdata[39:33];
            got.status     = rsp_tdata[41:40];
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result beat with nothing expected: value=%h found=%b count=%0d status=%0d",
                           $realtime, got.read_value, got.found, got.count, got.status);
            end else begin
               want = expected_rsp_q.pop_front();
               checked++;
               if (got.read_value !== want.read_value || got.found !== want.found ||
                   got.count !== want.count || got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: expected value=%h found=%b count=%0d status=%0d, got value=%h found=%b count=%0d status=%0d",
                              $realtime, want.read_value, want.found, want.count, want.status,
                              got.read_value, got.found, got.count, got.status);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(apply_array_op(req_tdata[3:0], req_tdata[10:4],
                                                    req_tdata[42:11]));
      end
      error_count   <= mismatches;
      checked_count <= checked;
      pending       <= expected_rsp_q.size();
      stored_count  <= shadow_count[CNT_OUT_W-1:0];
   end

endmodule

### test/tb_indexed_insert_remove_array_top.sv
// Testbench top for the indexed insert/remove array: clock, reset, request
// stimulus in bursts, result back-pressure and the verdict.
// Depends on iira_pkg, the block and indexed_insert_remove_array_checker.
`timescale 1ns / 100ps
module tb_indexed_insert_remove_array_top;
   import iira_pkg::*;

   localparam int EP_GROW   = 0;
   localparam int EP_SHRINK = 1;
   localparam int EP_MIXED  = 2;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [3:0] op, [10:4] position, [42:11] value, [47:43] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] read_value, [32] found, [39:33] count, [41:40] status, [47:42] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int                     error_count;
   int                     pending;
   int                     checked_count;
   logic [CNT_OUT_W-1:0]   level_hint;

   int                     burst_left = 0;
   int                     items_sent = 0;
   bit                     hold_rsp = 1'b0;

   logic [DATA_W-1:0] value_pool [8] = '{32'h0000_0005, 32'hFFFF_FFF9, 32'h0000_0000,
                                         32'h7FFF_FFFF, 32'h8000_0000, 32'hDEAD_BEEF,
                                         32'h0000_0100, 32'hFFFF_FFFF};

   indexed_insert_remove_array_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   indexed_insert_remove_array_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending       (pending),
      .checked_count (checked_count),
      .stored_count  (level_hint)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one request beat and hold it until taken; idle between bursts.
   task automatic send_beat(input logic [3:0] op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
         else burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, val, pos, op};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_random(input int flavor);
      int                r;
      int                r2;
      int                ins_lim, rem_lim, rd_lim, srch_lim, unk_lim;
      logic [3:0]        op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      r = $urandom_range(0, 99);
      case (flavor)
         EP_GROW: begin
            ins_lim = 60; rem_lim = 68; rd_lim = 80; srch_lim = 94; unk_lim = 100;
         end
         EP_SHRINK: begin
            ins_lim = 15; rem_lim = 70; rd_lim = 82; srch_lim = 94; unk_lim = 97;
         end
         default: begin
            ins_lim = 35; rem_lim = 60; rd_lim = 75; srch_lim = 90; unk_lim = 95;
         end
      endcase
      if (r < ins_lim)       op = 4'(OP_INSERT_AT) + 4'($urandom_range(0, 2));
      else if (r < rem_lim)  op = 4'(OP_REMOVE_AT) + 4'($urandom_range(0, 2));
      else if (r < rd_lim)   op = OP_READ;
      else if (r < srch_lim) op = OP_SEARCH;
      else if (r < unk_lim)  op = 4'(OP_CLEAR) + 4'($urandom_range(1, 7));
      else                   op = OP_CLEAR;
      // keep most indices near the live count so shifts hit real entries
      r2 = $urandom_range(0, 9);
      if (r2 < 7)      pos = POS_W'($urandom_range(0, int'(level_hint)));
      else if (r2 < 9) pos = POS_W'($urandom_range(0, CAPACITY));
      else             pos = POS_W'($urandom);
      r2 = $urandom_range(0, 99);
      if (r2 < 40)      val = value_pool[$urandom_range(0, 7)];
      else if (r2 < 45) val = value_pool[$urandom_range(2, 4)];
      else              val = $urandom;
      send_beat(op, pos, val);
   endtask

   // Receiver: ready pattern changes mode now and then; one long hold-off on request.
   initial begin : receiver
      int mode = 0;
      int span = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(16, 160);
            end
            span--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #4800000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int  flavor;
      int  len;
      int  waited;
      bit  hold_done;
      hold_done = 1'b0;
      waited = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty array corners
      send_beat(OP_REMOVE_FRONT, 7'd0, 32'h0);
      send_beat(OP_REMOVE_BACK, 7'd0, 32'h0);
      send_beat(OP_REMOVE_AT, 7'd0, 32'h0);
      send_beat(OP_READ, 7'd0, 32'h0);
      send_beat(OP_INSERT_AT, 7'd1, 32'h1);
      send_beat(OP_SEARCH, 7'd0, 32'h0);
      // build a small array with extreme values
      send_beat(OP_INSERT_AT, 7'd0, 32'h7FFF_FFFF);
      send_beat(OP_INSERT_FRONT, 7'd0, 32'h8000_0000);
      send_beat(OP_INSERT_BACK, 7'd0, 32'hFFFF_FFFF);
      send_beat(OP_INSERT_AT, 7'd3, 32'h0);
      send_beat(OP_INSERT_AT, 7'd2, 32'h1234_5678);
      send_beat(OP_READ, 7'd0, 32'h0);
      send_beat(OP_READ, 7'd4, 32'h0);
      send_beat(OP_READ, 7'd5, 32'h0);
      send_beat(OP_READ, 7'h7F, 32'hFFFF_FFFF);
      send_beat(OP_SEARCH, 7'd0, 32'h8000_0000);
      send_beat(OP_SEARCH, 7'd0, 32'h0000_0001);
      send_beat(OP_REMOVE_AT, 7'd2, 32'h0);
      send_beat(OP_REMOVE_AT, 7'd64, 32'h0);
      send_beat(OP_REMOVE_FRONT, 7'd0, 32'h0);
      send_beat(OP_REMOVE_BACK, 7'd0, 32'h0);
      send_beat(4'(OP_CLEAR) + 4'd1, 7'd0, 32'h0);
      send_beat(4'hF, 7'h7F, 32'hFFFF_FFFF);
      send_beat(OP_CLEAR, 7'd0, 32'h0);
      send_beat(OP_READ, 7'd0, 32'h0);
      wait_drained();

      // fill to capacity, then probe the full array
      send_beat(OP_CLEAR, 7'd0, 32'h0);
      for (int i = 0; i < CAPACITY; i++) begin
         case ($urandom_range(0, 2))
            0:       send_beat(OP_INSERT_FRONT, 7'd0, $urandom);
            1:       send_beat(OP_INSERT_BACK, 7'd0, value_pool[$urandom_range(0, 7)]);
            default: send_beat(OP_INSERT_AT, POS_W'($urandom_range(0, i)), $urandom);
         endcase
      end
      send_beat(OP_INSERT_BACK, 7'd0, 32'h5);
      send_beat(OP_INSERT_AT, 7'd65, 32'h5);
      send_beat(OP_INSERT_AT, 7'd64, 32'h5);
      send_beat(OP_INSERT_FRONT, 7'd0, 32'h5);
      send_beat(OP_READ, 7'd63, 32'h0);
      send_beat(OP_READ, 7'd64, 32'h0);
      send_beat(OP_SEARCH, 7'd0, value_pool[1]);
      send_beat(OP_REMOVE_AT, 7'd63, 32'h0);
      send_beat(OP_INSERT_AT, 7'd63, 32'hA5A5_5A5A);
      send_beat(OP_REMOVE_AT, 7'd64, 32'h0);
      wait_drained();

      // random episodes that grow, shrink or mix the array
      while (items_sent < RANDOM_ITEMS - 100) begin
         flavor = $urandom_range(EP_GROW, EP_MIXED);
         len = (flavor == EP_GROW) ? $urandom_range(80, 220) : $urandom_range(40, 150);
         for (int k = 0; k < len; k++) begin
            if (!hold_done && items_sent >= 700) begin
               hold_rsp = 1'b1;
               hold_done = 1'b1;
            end
            send_random(flavor);
         end
         if ($urandom_range(0, 3) == 0) wait_drained();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending != 0) begin
         $display("Some tests failed");
         $finish;
      end else begin
         repeat (4) @(posedge clock);
         $display("Covered %0d request beats: empty and full corners, fill to capacity,",
                  items_sent);
         $display("random grow/shrink/mix episodes; %0d results compared, %0d mismatches.",
                  checked_count, error_count);
         if (error_count == 0) begin
            $display("All tests passed");
         end else begin
            $display("Some tests failed");
         end
         $finish;
      end
   end

endmodule
